// File: design/tlb_pkg.sv
// ----------------------------------------------------------------------------
// tlb_pkg
// shared types and codes of the translate unit
// ----------------------------------------------------------------------------
package tlb_pkg;

  typedef enum logic [1:0] {
    MODE_TRANSLATE = 2'd0,
    MODE_FILL      = 2'd1,
    MODE_REMAP     = 2'd2,
    MODE_FLUSH     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_ENTRIES = 2'd0,
    CFG_POLICY  = 2'd1,
    CFG_PAGE    = 2'd2,
    CFG_FANOUT  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_DIV2,
    ST_SCAN,
    ST_LRU,
    ST_MUL,
    ST_OUT
  } state_t;

  localparam int unsigned PAGE_W  = 32;
  localparam int unsigned FRAME_W = 20;
  localparam int unsigned STAMP_W = 32;

  // one entry as it moves along the row
  typedef struct packed {
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // control broadcast to every cell
  typedef struct packed {
    logic               rotate;
    logic               lookup;
    logic               remap;
    logic               drop;
    logic [PAGE_W-1:0]  key_page;
    logic [FRAME_W-1:0] key_frame;
    logic [STAMP_W-1:0] stamp;
  } cell_ctl_t;

endpackage

// File: design/tlb_fifo_lru_translate_unit.sv
// ----------------------------------------------------------------------------
// tlb_fifo_lru_translate_unit
// fully associative tlb with fifo or lru replacement
// ----------------------------------------------------------------------------
// Entries sit in a row of cells in queue order, oldest in cell 0. Translate
// runs two divisions (page and offset, then the two-level indices) through one
// shared bit-serial divider, then the parallel match, then the output state,
// and returns to idle to take the next item. Fill and remap pass through the
// scan and output states, flush only through the output state; a fill into a
// full tlb with fifo drops the head in one shift, and with lru the victim
// search steps through one cell per cycle before the row closes the gap in one
// shift. One item is worked on at a time; the result register frees the input
// as soon as the result is stored, and the output state waits while an earlier
// result is still held.
module tlb_fifo_lru_translate_unit
  import tlb_pkg::*;
#(
  parameter int unsigned TLB_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // mode[1:0], logical_address[33:2], page_number[65:34], frame_number[85:66]
  input  logic [87:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // hit[0], frame_out[20:1], physical_address[52:21], page_out[84:53],
  // first_level_index[116:85], second_level_index[126:117]
  output logic [127:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [16:0]  cfg_data
);

  localparam int unsigned CW = $clog2(TLB_DEPTH + 1);
  localparam int unsigned IW = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;

  logic [4:0]  entries_r;
  logic        policy_r;
  logic [16:0] page_size_r;
  logic [10:0] fanout_r;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0] use_r, use_nxt, stamp_new;
  logic [1:0]  mode_r;
  logic [31:0] addr_r, page_in_r;
  logic [19:0] frame_in_r;
  logic [31:0] page_r;
  logic [16:0] offset_r;
  logic        hit_r;
  logic [19:0] frm_r;
  logic [CW-1:0] rot_r, rot_nxt;
  logic [CW-1:0] cap;
  logic [31:0] best_r;
  logic [IW-1:0] vic_r;

  logic        out_valid_r;
  logic [127:0] out_data_r;

  cell_ctl_t ctl;
  entry_t    ent   [TLB_DEPTH];
  entry_t    prv   [TLB_DEPTH];
  logic      act   [TLB_DEPTH];
  logic      ld    [TLB_DEPTH];
  logic      hits  [TLB_DEPTH];
  entry_t    new_entry;

  logic        div_start, div_busy;
  logic [31:0] div_a, div_q;
  logic [16:0] div_b, div_rm;

  logic [19:0] win_frame;
  logic        any_hit;
  logic        do_out;
  logic [52:0] prod;

  mode_t in_mode;
  assign in_mode = mode_t'(in_tdata[1:0]);

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    if (entries_r == 5'd0) begin
      cap = CW'(1);
    end else if ({27'd0, entries_r} > 32'(TLB_DEPTH)) begin
      cap = CW'(TLB_DEPTH);
    end else begin
      cap = CW'(entries_r);
    end
  end

  assign stamp_new = (use_r == 32'hFFFF_FFFF) ? use_r : use_r + 32'd1;

  always_comb begin
    any_hit   = 1'b0;
    win_frame = 20'd0;
    for (int i = 0; i < TLB_DEPTH; i++) begin
      if (hits[i]) begin
        any_hit   = 1'b1;
        win_frame = ent[i].frame;
      end
    end
  end

  assign new_entry = '{page: page_in_r, frame: frame_in_r, stamp: use_r};

  assign div_a = (state_r == ST_DIV1) ? addr_r : page_r;
  assign div_b = (state_r == ST_DIV1) ? page_size_r : {6'd0, fanout_r};

  tlb_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_rm)
  );

  assign prod = 53'(frm_r) * 53'((page_size_r == 17'd0) ? 17'd1 : page_size_r);

  // shift closes the gap: victim..tail-1 take neighbor, tail takes new entry
  logic shift_row;
  always_comb begin
    for (int i = 0; i < TLB_DEPTH; i++) begin
      prv[i] = (i == TLB_DEPTH - 1) ? ent[i] : ent[i + ((i < TLB_DEPTH - 1) ? 1 : 0)];
      act[i] = CW'(i) < count_r;
      ld[i]  = 1'b0;
    end
    ctl          = '0;
    ctl.key_page = (mode_r == MODE_REMAP) ? page_in_r : page_r;
    ctl.key_frame = frame_in_r;
    ctl.stamp    = use_r;
    ctl.rotate   = 1'b0;
    shift_row    = 1'b0;
    state_nxt    = state_r;
    count_nxt    = count_r;
    use_nxt      = use_r;
    rot_nxt      = rot_r;
    div_start    = 1'b0;
    do_out       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          case (in_mode)
            MODE_TRANSLATE: begin
              use_nxt   = stamp_new;
              state_nxt = ST_DIV1;
            end
            MODE_FILL, MODE_REMAP: begin
              use_nxt   = stamp_new;
              state_nxt = ST_SCAN;
            end
            default: begin
              count_nxt = '0;
              state_nxt = ST_OUT;
            end
          endcase
        end
      end
      ST_DIV1: begin
        div_start = (rot_r == '0);
        rot_nxt   = CW'(1);
        if (rot_r != '0 && !div_busy) begin
          rot_nxt   = '0;
          state_nxt = ST_DIV2;
        end
      end
      ST_DIV2: begin
        div_start = (rot_r == '0);
        rot_nxt   = CW'(1);
        if (rot_r != '0 && !div_busy) begin
          rot_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_SCAN: begin
        state_nxt = ST_OUT;
        if (mode_r == MODE_REMAP) begin
          ctl.remap = 1'b1;
        end else if (count_r < cap) begin
          for (int i = 0; i < TLB_DEPTH; i++) begin
            ld[i] = (CW'(i) == count_r);
          end
          count_nxt = count_r + CW'(1);
        end else begin
          // fifo drops the head, lru searches for the victim first
          rot_nxt   = policy_r ? CW'(1) : count_r;
          state_nxt = ST_LRU;
        end
      end
      ST_LRU: begin
        if (rot_r < count_r) begin
          rot_nxt = rot_r + CW'(1);
        end else begin
          shift_row = 1'b1;
          rot_nxt   = '0;
          state_nxt = ST_OUT;
        end
      end
      ST_MUL: begin
        ctl.lookup = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          do_out    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // cell row
  entry_t cell_in [TLB_DEPTH];
  logic   cell_ld [TLB_DEPTH];
  always_comb begin
    for (int i = 0; i < TLB_DEPTH; i++) begin
      cell_in[i] = new_entry;
      cell_ld[i] = ld[i];
    end
    if (shift_row) begin
      for (int i = 0; i < TLB_DEPTH; i++) begin
        if (CW'(i) + CW'(1) == count_r) begin
          cell_ld[i] = 1'b1;
        end else if (CW'(i) + CW'(1) < count_r && IW'(i) >= vic_r) begin
          cell_ld[i] = 1'b1;
          cell_in[i] = prv[i];
        end
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < TLB_DEPTH; g++) begin : g_cell
      tlb_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .active     (act[g]),
        .prev_entry (prv[g]),
        .load       (cell_ld[g]),
        .load_entry (cell_in[g]),
        .entry      (ent[g]),
        .hit        (hits[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      use_r       <= '0;
      rot_r       <= '0;
      entries_r   <= 5'd4;
      policy_r    <= 1'b0;
      page_size_r <= 17'd64;
      fanout_r    <= 11'd4;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      use_r   <= use_nxt;
      rot_r   <= rot_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ENTRIES: entries_r   <= cfg_data[4:0];
          CFG_POLICY:  policy_r    <= cfg_data[0];
          CFG_PAGE:    page_size_r <= cfg_data;
          CFG_FANOUT:  fanout_r    <= cfg_data[10:0];
          default:     entries_r   <= entries_r;
        endcase
      end
      if (do_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // lru victim: first smallest stamp in queue order, one cell per cycle
  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN) begin
      best_r <= ent[0].stamp;
      vic_r  <= '0;
    end else if (state_r == ST_LRU && rot_r < count_r &&
                 ent[IW'(rot_r)].stamp < best_r) begin
      best_r <= ent[IW'(rot_r)].stamp;
      vic_r  <= IW'(rot_r);
    end
  end

  logic [31:0] fli_r;
  logic [9:0]  sli_r;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r     <= in_tdata[1:0];
      addr_r     <= in_tdata[33:2];
      page_in_r  <= in_tdata[65:34];
      frame_in_r <= in_tdata[85:66];
      page_r     <= '0;
      offset_r   <= '0;
      fli_r      <= '0;
      sli_r      <= '0;
      hit_r      <= 1'b0;
      frm_r      <= '0;
    end
    if (state_r == ST_DIV1 && rot_r != '0 && !div_busy) begin
      page_r   <= div_q;
      offset_r <= div_rm;
    end
    if (state_r == ST_DIV2 && rot_r != '0 && !div_busy) begin
      fli_r <= div_q;
      sli_r <= div_rm[9:0];
    end
    if (state_r == ST_MUL) begin
      hit_r <= any_hit;
      frm_r <= any_hit ? win_frame : 20'd0;
    end
    if (do_out) begin
      out_data_r <= {1'b0,
                     (mode_r == MODE_TRANSLATE) ? sli_r : 10'd0,
                     (mode_r == MODE_TRANSLATE) ? fli_r : 32'd0,
                     (mode_r == MODE_TRANSLATE) ? page_r : 32'd0,
                     (mode_r == MODE_TRANSLATE && hit_r) ?
                       prod[31:0] + {15'd0, offset_r} : 32'd0,
                     (mode_r == MODE_TRANSLATE) ? frm_r : 20'd0,
                     (mode_r == MODE_TRANSLATE) ? hit_r : 1'b0};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TLB_DEPTH))
    else $error("entry count beyond depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == ST_IDLE)
    else $error("input taken while busy");

endmodule

// File: design/tlb_cell.sv
// ----------------------------------------------------------------------------
// tlb_cell
// one entry of the rotating row: holds an entry, matches it, passes it on
// ----------------------------------------------------------------------------
module tlb_cell
  import tlb_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      active,
  input  entry_t    prev_entry,
  input  logic      load,
  input  entry_t    load_entry,
  output entry_t    entry,
  output logic      hit
);

  entry_t entry_r;
  entry_t entry_nxt;

  assign entry = entry_r;
  assign hit   = active && ctl.lookup && (entry_r.page == ctl.key_page);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.lookup && active && entry_r.page == ctl.key_page) begin
      entry_nxt.stamp = ctl.stamp;
    end
    if (ctl.remap && active && entry_r.frame == ctl.key_frame) begin
      entry_nxt.page  = ctl.key_page;
      entry_nxt.stamp = ctl.stamp;
    end
    if (ctl.rotate) begin
      entry_nxt = prev_entry;
    end
    if (load) begin
      entry_nxt = load_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// File: design/tlb_divider.sv
// ----------------------------------------------------------------------------
// tlb_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tlb_divider
  import tlb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [31:0]       dividend,
  input  logic [16:0]       divisor,
  output logic              busy,
  output logic [31:0]       quotient,
  output logic [16:0]       remainder
);

  logic [31:0] quo_r, quo_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [16:0] div_r, div_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [17:0] trial;

  assign busy      = (cnt_r != 6'd0);
  assign quotient  = quo_r;
  assign remainder = rem_r[16:0];
  assign trial     = {rem_r[16:0], quo_r[31]};

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    div_nxt = div_r;
    cnt_nxt = cnt_r;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = 18'd0;
      div_nxt = (divisor == 17'd0) ? 17'd1 : divisor;
      cnt_nxt = 6'd32;
    end else if (busy) begin
      cnt_nxt = cnt_r - 6'd1;
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = trial - {1'b0, div_r};
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 6'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

endmodule
